[rtl/script_text_tokenizer_unit_macros.svh]
// Assertion macros used by the port-level checker.
`ifndef SCRIPT_TEXT_TOKENIZER_UNIT_MACROS_SVH
`define SCRIPT_TEXT_TOKENIZER_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define STT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define STT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/stt_pkg.sv]
// Shared types and constants of the script text tokenizer.
package stt_pkg;
	localparam int MAX_TEXT_BYTES = 64;
	localparam int TEXT_CAP = (MAX_TEXT_BYTES - 1) < 63 ? (MAX_TEXT_BYTES - 1) : 63;
	localparam int IDX_W = $clog2(MAX_TEXT_BYTES);

	typedef enum logic [3:0] {
		K_STR = 4'd0, K_INT = 4'd1, K_BOOL = 4'd2, K_EQ = 4'd3, K_OBR = 4'd4,
		K_CBR = 4'd5, K_LT = 4'd6, K_GT = 4'd7, K_DEC = 4'd8, K_EOF = 4'd9
	} kind_t;

	typedef struct packed {
		logic [3:0]         kind;
		logic [7:0]         text_char;
		logic [5:0]         text_length;
		logic signed [63:0] int_value;
		logic               int_invalid;
		logic               bool_value;
		logic               text_too_long;
		logic [31:0]        line_number;
		logic [31:0]        first_column;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	// Command from front to back: optional run, then up to two single items.
	typedef struct packed {
		logic          do_run;
		logic [3:0]    run_kind;
		logic [5:0]    run_len;
		logic          run_tl;
		logic [31:0]   run_line;
		logic [31:0]   run_col;
		logic [1:0]    n_single;
		result_t       s0;
		result_t       s1;
	} cmd_t;
endpackage

[rtl/stt_stream_if.sv]
// Valid/ready channel carrying a generic payload.
interface stt_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/stt_front.sv]
// Front end: accepts bytes, updates token state, and issues emit commands.
module stt_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  stt_pkg::in_item_t  in_data,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output stt_pkg::cmd_t      cmd_data,
	output logic               wr_en,
	output logic [stt_pkg::IDX_W-1:0] wr_addr,
	output logic [7:0]         wr_byte,
	input  logic               busy_run
);
	import stt_pkg::*;

	localparam logic [1:0] G_NONE = 2'd0, G_STRING = 2'd1, G_INT = 2'd2, G_DOUBLE = 2'd3;
	localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	logic [6:0]  len_q;
	logic [31:0] run_q;
	logic [1:0]  guess_q;
	logic        quote_q;
	logic [31:0] line_q, col_q;
	logic [63:0] acc_q;
	logic        bad_q, neg_q;
	logic [7:0]  b0_q, b1_q, b2_q;
	// Two-phase: the first phase latches the byte and the widened acc * 10 + digit.
	logic        ph_q;
	in_item_t    it_s1;
	logic [67:0] acc10_s1;

	assign in_ready = !ph_q && cmd_ready;

	logic [7:0] c;
	logic       space, digit, isq;
	logic [3:0] sk;
	logic [3:0] dval;
	assign c = it_s1.text_byte;
	assign space = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	assign digit = (c >= 8'h30) && (c <= 8'h39);
	assign isq = (c == 8'h22);
	assign dval = c[3:0];
	always_comb begin
		unique case (c)
			8'h3D: sk = K_EQ;
			8'h7B: sk = K_OBR;
			8'h7D: sk = K_CBR;
			8'h3C: sk = K_LT;
			8'h3E: sk = K_GT;
			default: sk = 4'd0;
		endcase
	end

	logic [7:0] din;
	logic [3:0] din_d;
	assign din = in_data.text_byte;
	assign din_d = din[3:0];

	logic [31:0] col_inc;
	assign col_inc = (col_q != 32'hFFFF_FFFF) ? col_q + 32'd1 : col_q;

	logic [63:0] lim;
	assign lim = neg_q ? {1'b1, 63'd0} : LIM_POS;

	// Overflow when acc * 10 + digit exceeds the signed bound.
	logic ovf;
	assign ovf = acc10_s1 > {4'd0, lim};

	result_t z;
	always_comb begin
		z = '0;
		z.line_number = line_q;
	end

	logic fin, app;
	assign app = quote_q || (!space && sk == 4'd0);

	logic is_yes, is_no;
	assign is_yes = (run_q == 32'd3) && (len_q == 7'd3) && ((b0_q | 8'h20) == 8'h79)
		&& ((b1_q | 8'h20) == 8'h65) && ((b2_q | 8'h20) == 8'h73);
	assign is_no = (run_q == 32'd2) && (len_q == 7'd2) && ((b0_q | 8'h20) == 8'h6E)
		&& ((b1_q | 8'h20) == 8'h6F);

	always_comb begin
		logic [31:0] fcol;
		logic        ib;
		result_t     tk;
		logic        has_tk, do_run;
		logic [3:0]  rk;
		result_t     sp, eo;
		logic        has_sp, has_eo, pend;
		logic [1:0]  ns;
		fcol = (col_inc > run_q) ? col_inc - run_q : 32'd0;
		fin = app ? (isq && quote_q) : 1'b1;
		tk = z;
		tk.first_column = fcol;
		has_tk = 1'b0;
		do_run = 1'b0;
		rk = K_STR;
		ib = bad_q || (neg_q && run_q == 32'd1);
		if (fin) begin
			unique case (guess_q)
				G_STRING: begin
					if (is_yes || is_no) begin
						has_tk = 1'b1;
						tk.kind = K_BOOL;
						tk.bool_value = is_yes;
					end else begin
						do_run = 1'b1;
					end
				end
				G_INT: begin
					has_tk = 1'b1;
					tk.kind = K_INT;
					tk.int_invalid = ib;
					tk.int_value = ib ? 64'sd0 : (neg_q ? -$signed(acc_q) : $signed(acc_q));
				end
				G_DOUBLE: begin
					do_run = 1'b1;
					rk = K_DEC;
				end
				default: ;
			endcase
		end
		sp = z;
		sp.kind = sk;
		sp.first_column = col_inc;
		has_sp = !app && sk != 4'd0;
		pend = fin ? 1'b0 : (guess_q != G_NONE || quote_q || (isq && !quote_q));
		if (app && !isq && guess_q == G_NONE) pend = 1'b1;
		eo = z;
		eo.kind = K_EOF;
		eo.first_column = (c == 8'h0A) ? 32'd0 : col_inc;
		if (c == 8'h0A && line_q != 32'hFFFF_FFFF) eo.line_number = line_q + 32'd1;
		has_eo = it_s1.end_of_text && pend;
		ns = 2'(has_tk) + 2'(has_sp) + 2'(has_eo);
		cmd_data = '0;
		cmd_data.do_run = do_run;
		cmd_data.run_kind = rk;
		cmd_data.run_len = len_q[5:0];
		cmd_data.run_tl = run_q > 32'(len_q);
		cmd_data.run_line = line_q;
		cmd_data.run_col = fcol;
		cmd_data.n_single = ns;
		if (has_tk) begin
			cmd_data.s0 = tk;
			cmd_data.s1 = has_sp ? sp : eo;
		end else if (has_sp) begin
			cmd_data.s0 = sp;
			cmd_data.s1 = eo;
		end else begin
			cmd_data.s0 = eo;
			cmd_data.s1 = z;
		end
	end

	assign cmd_valid = ph_q;
	assign wr_en = ph_q && cmd_ready && app && !isq && len_q < 7'(TEXT_CAP) && !busy_run;
	assign wr_addr = len_q[IDX_W-1:0];
	assign wr_byte = c;

	logic ok;
	assign ok = ph_q && cmd_ready && !busy_run;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			it_s1 <= in_data;
			acc10_s1 <= ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + 68'(din_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 1'b0;
			len_q <= '0; run_q <= '0; guess_q <= G_NONE; quote_q <= 1'b0;
			line_q <= 32'd1; col_q <= '0; acc_q <= '0; bad_q <= 1'b0; neg_q <= 1'b0;
			b0_q <= '0; b1_q <= '0; b2_q <= '0;
		end else begin
			if (in_valid && in_ready) ph_q <= 1'b1;
			else if (ok) begin
				ph_q <= 1'b0;
				col_q <= (c == 8'h0A) ? 32'd0 : col_inc;
				if (c == 8'h0A && line_q != 32'hFFFF_FFFF) line_q <= line_q + 32'd1;
				if (app) begin
					if (isq) begin
						if (quote_q) quote_q <= 1'b0;
						else begin
							quote_q <= 1'b1;
							guess_q <= G_STRING;
						end
					end else begin
						if (run_q != 32'hFFFF_FFFF) run_q <= run_q + 32'd1;
						if (len_q < 7'(TEXT_CAP)) begin
							len_q <= len_q + 7'd1;
							if (len_q == 7'd0) b0_q <= c;
							if (len_q == 7'd1) b1_q <= c;
							if (len_q == 7'd2) b2_q <= c;
						end
						unique case (guess_q)
							G_NONE: begin
								if (digit) begin
									guess_q <= G_INT;
									acc_q <= 64'(dval);
								end else if (c == 8'h2D) begin
									guess_q <= G_INT;
									neg_q <= 1'b1;
								end else guess_q <= G_STRING;
							end
							G_INT: begin
								if (c == 8'h2E) guess_q <= G_DOUBLE;
								else if (digit && !bad_q) begin
									if (ovf) bad_q <= 1'b1;
									else acc_q <= acc10_s1[63:0];
								end else if (!digit) bad_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				if (fin) begin
					guess_q <= G_NONE; len_q <= '0; run_q <= '0;
					acc_q <= '0; bad_q <= 1'b0; neg_q <= 1'b0;
				end
				if (it_s1.end_of_text) begin
					guess_q <= G_NONE; len_q <= '0; run_q <= '0;
					acc_q <= '0; bad_q <= 1'b0; neg_q <= 1'b0;
					quote_q <= 1'b0; line_q <= 32'd1; col_q <= '0;
				end
			end
		end
	end
endmodule

[rtl/stt_back.sv]
// Back end: owns the text buffer, plays out commands as result transactions.
module stt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  stt_pkg::cmd_t      cmd_data,
	input  logic               wr_en,
	input  logic [stt_pkg::IDX_W-1:0] wr_addr,
	input  logic [7:0]         wr_byte,
	output logic               busy_run,
	output logic               out_valid,
	input  logic               out_ready,
	output stt_pkg::result_t   out_data
);
	import stt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_RUN = 4'b0010, S_S0 = 4'b0100, S_S1 = 4'b1000
	} bstate_t;

	logic [7:0] mem [MAX_TEXT_BYTES];
	bstate_t    st_q;
	cmd_t       cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [7:0] rd_q;
	logic       rdv_q;
	logic       ovalid_q;
	result_t    odata_q;

	assign cmd_ready = (st_q == S_IDLE) && !ovalid_q;
	assign busy_run = (st_q != S_IDLE);
	assign out_valid = ovalid_q;
	assign out_data = odata_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_byte;
		rd_q <= mem[idx_q];
	end

	logic free;
	assign free = !ovalid_q || out_ready;

	result_t rr;
	logic    run_last;
	always_comb begin
		rr = '0;
		rr.kind = cmd_q.run_kind;
		rr.text_char = (cmd_q.run_len == 6'd0) ? 8'd0 : rd_q;
		rr.text_length = cmd_q.run_len;
		rr.text_too_long = cmd_q.run_tl;
		rr.line_number = cmd_q.run_line;
		rr.first_column = cmd_q.run_col;
		run_last = (cmd_q.run_len == 6'd0) || (7'(idx_q) + 7'd1 >= 7'(cmd_q.run_len));
		rr.last_of_run = run_last && cmd_q.n_single == 2'd0;
	end

	result_t s0_o, s1_o;
	always_comb begin
		s0_o = cmd_q.s0;
		s0_o.last_of_run = cmd_q.n_single == 2'd1;
		s1_o = cmd_q.s1;
		s1_o.last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ovalid_q <= 1'b0;
			rdv_q <= 1'b0;
			idx_q <= '0;
			cmd_q <= '0;
			odata_q <= '0;
		end else begin
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd_data;
						idx_q <= '0;
						rdv_q <= 1'b0;
						if (cmd_data.do_run) st_q <= S_RUN;
						else if (cmd_data.n_single != 2'd0) st_q <= S_S0;
					end
				end
				S_RUN: begin
					// Wait for the registered read of each byte before presenting it.
					if (!rdv_q) rdv_q <= 1'b1;
					else if (free) begin
						odata_q <= rr;
						ovalid_q <= 1'b1;
						rdv_q <= 1'b0;
						if (run_last) st_q <= (cmd_q.n_single != 2'd0) ? S_S0 : S_IDLE;
						else idx_q <= idx_q + 1'b1;
					end
				end
				S_S0: begin
					if (free) begin
						odata_q <= s0_o;
						ovalid_q <= 1'b1;
						st_q <= (cmd_q.n_single == 2'd1) ? S_IDLE : S_S1;
					end
				end
				S_S1: begin
					if (free) begin
						odata_q <= s1_o;
						ovalid_q <= 1'b1;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/script_text_tokenizer_unit.sv]
// Script text tokenizer: byte in, token items out.
// The front registers each accepted byte, then issues its command; the back end reads run bytes
// from its buffer through a registered read before presenting them.
// A new byte is accepted only once the previous command is taken, the back end is idle and
// no result is waiting, so any output stall also holds the input.
// Reset: arst_n clears line to 1, column to 0, and all token state at once.
module script_text_tokenizer_unit (
	input logic clk,
	input logic arst_n,
	stt_stream_if.sink   in_ch,
	stt_stream_if.source out_ch
);
	import stt_pkg::*;

	logic  cmd_valid, cmd_ready, wr_en, busy_run;
	cmd_t  cmd_data;
	logic [IDX_W-1:0] wr_addr;
	logic [7:0] wr_byte;

	stt_front u_front (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.cmd_valid, .cmd_ready, .cmd_data, .wr_en, .wr_addr, .wr_byte, .busy_run
	);

	stt_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd_data, .wr_en, .wr_addr, .wr_byte,
		.busy_run,
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
	);
endmodule

[rtl/stt_checker.sv]
// Port-level checker for the tokenizer, bound to the top level.
`include "script_text_tokenizer_unit_macros.svh"
module stt_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [3:0] kind,
	input logic [31:0] line_number,
	input logic int_invalid,
	input logic [63:0] int_value
);
	import stt_pkg::*;
	`STT_ASSERT_IMPL(a_kind_range, clk, arst_n, out_valid, kind <= K_EOF)
	`STT_ASSERT_IMPL(a_line_nonzero, clk, arst_n, out_valid, line_number != 32'd0)
	`STT_ASSERT_IMPL(a_invalid_zero, clk, arst_n, out_valid && int_invalid, int_value == 64'd0)
	`STT_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule

bind script_text_tokenizer_unit stt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.kind(out_ch.data.kind), .line_number(out_ch.data.line_number),
	.int_invalid(out_ch.data.int_invalid), .int_value(out_ch.data.int_value)
);

[verif/script_text_tokenizer_unit_checker.sv]
// Token predictor and scoreboard that watches the text and token channels.
`timescale 1ns / 1ps
module script_text_tokenizer_unit_checker
	import stt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     text_valid,
	input  logic     text_ready,
	input  in_item_t text_data,
	input  logic     token_valid,
	input  logic     token_ready,
	input  result_t  token_data,
	output int       mismatch_count,
	output int       tokens_pending
);
	localparam logic [1:0] GUESS_NONE = 2'd0;
	localparam logic [1:0] GUESS_STRING = 2'd1;
	localparam logic [1:0] GUESS_INT = 2'd2;
	localparam logic [1:0] GUESS_DECIMAL = 2'd3;
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	logic [7:0]  buf_text [0:MAX_TEXT_BYTES-1];
	logic [31:0] buf_len;
	logic [31:0] seen_len;
	logic [1:0]  guess;
	logic        quoted;
	logic [31:0] line_no;
	logic [31:0] col_no;
	logic [63:0] magnitude;
	logic        num_bad;
	logic        minus;

	result_t expected_tokens[$];
	result_t step_tokens[$];

	assign tokens_pending = expected_tokens.size();

	task automatic clear_word();
		guess = GUESS_NONE;
		buf_len = 0;
		seen_len = 0;
		magnitude = 0;
		num_bad = 1'b0;
		minus = 1'b0;
	endtask

	task automatic reset_tokenizer();
		clear_word();
		quoted = 1'b0;
		line_no = 1;
		col_no = 0;
	endtask

	task automatic add_token(kind_t k, logic [7:0] ch, logic [5:0] len, logic [63:0] val,
			logic inv, logic bval, logic tl, logic [31:0] col);
		result_t r;
		if (step_tokens.size() >= 64)
			return;
		r.kind = k;
		r.text_char = ch;
		r.text_length = len;
		r.int_value = val;
		r.int_invalid = inv;
		r.bool_value = bval;
		r.text_too_long = tl;
		r.line_number = line_no;
		r.first_column = col;
		r.last_of_run = 1'b0;
		step_tokens.insert(step_tokens.size(), r);
	endtask

	function automatic logic word_matches(string w);
		if (seen_len != w.len() || buf_len != w.len())
			return 1'b0;
		for (int i = 0; i < w.len(); i++)
			if ((buf_text[i] | 8'h20) != w[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic add_byte_run(kind_t k, logic [31:0] col);
		logic tl;
		tl = seen_len > buf_len;
		if (buf_len == 0) begin
			add_token(k, 8'd0, 6'd0, 64'd0, 1'b0, 1'b0, tl, col);
			return;
		end
		for (int i = 0; i < buf_len && i < TEXT_CAP; i++)
			add_token(k, buf_text[i], buf_len[5:0], 64'd0, 1'b0, 1'b0, tl, col);
	endtask

	task automatic close_word();
		logic [31:0] col;
		logic        bad;
		col = col_no > seen_len ? col_no - seen_len : 32'd0;
		case (guess)
			GUESS_STRING: begin
				if (word_matches("yes"))
					add_token(K_BOOL, 8'd0, 6'd0, 64'd0, 1'b0, 1'b1, 1'b0, col);
				else if (word_matches("no"))
					add_token(K_BOOL, 8'd0, 6'd0, 64'd0, 1'b0, 1'b0, 1'b0, col);
				else
					add_byte_run(K_STR, col);
			end
			GUESS_INT: begin
				bad = num_bad || (minus && seen_len == 1);
				add_token(K_INT, 8'd0, 6'd0, bad ? 64'd0 : (minus ? -magnitude : magnitude),
					bad, 1'b0, 1'b0, col);
			end
			GUESS_DECIMAL: add_byte_run(K_DEC, col);
			default: ;
		endcase
		clear_word();
	endtask

	task automatic take_byte(logic [7:0] c);
		logic        digit;
		logic [63:0] d;
		logic [63:0] limit;
		digit = c >= "0" && c <= "9";
		d = {56'd0, c - 8'd48};
		if (seen_len != COUNT_MAX)
			seen_len++;
		if (buf_len < TEXT_CAP) begin
			buf_text[buf_len] = c;
			buf_len++;
		end
		if (guess == GUESS_NONE) begin
			if (digit) begin
				guess = GUESS_INT;
				magnitude = d;
			end else if (c == "-") begin
				guess = GUESS_INT;
				minus = 1'b1;
			end else
				guess = GUESS_STRING;
		end else if (guess == GUESS_INT) begin
			limit = minus ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
			if (c == ".")
				guess = GUESS_DECIMAL;
			else if (digit && !num_bad) begin
				if (magnitude > (limit - d) / 10)
					num_bad = 1'b1;
				else
					magnitude = magnitude * 10 + d;
			end else if (!digit)
				num_bad = 1'b1;
		end
	endtask

	task automatic predict_tokens(logic [7:0] c, logic eot);
		logic  space;
		kind_t sk;
		space = c == " " || (c >= 8'd9 && c <= 8'd13);
		case (c)
			"=": sk = K_EQ;
			"{": sk = K_OBR;
			"}": sk = K_CBR;
			"<": sk = K_LT;
			">": sk = K_GT;
			default: sk = K_STR;
		endcase
		step_tokens.delete();
		if (col_no != COUNT_MAX)
			col_no++;
		if (quoted || (!space && sk == K_STR)) begin
			if (c == "\"") begin
				if (quoted) begin
					quoted = 1'b0;
					close_word();
				end else begin
					quoted = 1'b1;
					guess = GUESS_STRING;
				end
			end else
				take_byte(c);
		end else begin
			close_word();
			if (sk != K_STR)
				add_token(sk, 8'd0, 6'd0, 64'd0, 1'b0, 1'b0, 1'b0, col_no);
		end
		if (c == 8'd10) begin
			if (line_no != COUNT_MAX)
				line_no++;
			col_no = 0;
		end
		if (eot) begin
			if (guess != GUESS_NONE || quoted)
				add_token(K_EOF, 8'd0, 6'd0, 64'd0, 1'b0, 1'b0, 1'b0, col_no);
			reset_tokenizer();
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
		foreach (step_tokens[i])
			expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
	endtask

	task automatic report(string what, result_t e, result_t a);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %s exp kind=%0d ch=%h len=%0d val=%0d inv=%b b=%b",
				$time, what, e.kind, e.text_char, e.text_length, e.int_value, e.int_invalid,
				e.bool_value, " tl=%b ln=%0d col=%0d last=%b", e.text_too_long,
				e.line_number, e.first_column, e.last_of_run,
				" act kind=%0d ch=%h len=%0d val=%0d inv=%b b=%b",
				a.kind, a.text_char, a.text_length, a.int_value, a.int_invalid,
				a.bool_value, " tl=%b ln=%0d col=%0d last=%b", a.text_too_long,
				a.line_number, a.first_column, a.last_of_run);
	endtask

	initial begin
		mismatch_count = 0;
		reset_tokenizer();
	end

	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (token_valid && token_ready) begin
				if (expected_tokens.size() == 0) begin
					e = '0;
					report("unexpected token", e, token_data);
				end else begin
					e = expected_tokens.pop_front();
					if (e.kind != token_data.kind || e.text_char != token_data.text_char
							|| e.text_length != token_data.text_length
							|| e.int_value != token_data.int_value
							|| e.int_invalid != token_data.int_invalid
							|| e.bool_value != token_data.bool_value
							|| e.text_too_long != token_data.text_too_long
							|| e.line_number != token_data.line_number
							|| e.first_column != token_data.first_column
							|| e.last_of_run != token_data.last_of_run)
						report("token mismatch", e, token_data);
				end
			end
			if (text_valid && text_ready)
				predict_tokens(text_data.text_byte, text_data.end_of_text);
		end
	end
endmodule

[verif/script_text_tokenizer_unit_test.sv]
// Stimulus, clock, reset and verdict for the script text tokenizer.
`timescale 1ns / 1ps
module script_text_tokenizer_unit_test;
	import stt_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	int   mismatch_count;
	int   tokens_pending;
	int   idle_cycles;
	int   send_idle_pct;
	int   stall_pct;
	int   bytes_sent;

	stt_stream_if #(.T(in_item_t)) text_ch();
	stt_stream_if #(.T(result_t)) token_ch();

	script_text_tokenizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(text_ch.sink),
		.out_ch(token_ch.source)
	);

	script_text_tokenizer_unit_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_ch.valid),
		.text_ready(text_ch.ready),
		.text_data(text_ch.data),
		.token_valid(token_ch.valid),
		.token_ready(token_ch.ready),
		.token_data(token_ch.data),
		.mismatch_count(mismatch_count),
		.tokens_pending(tokens_pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		text_ch.valid = 1'b0;
		text_ch.data = '0;
		token_ch.ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
	end

	always @(posedge clk)
		token_ch.ready <= $urandom_range(0, 99) >= stall_pct;

	always @(posedge clk) begin
		if (!arst_n || (text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic eot);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data <= '{text_byte: b, end_of_text: eot};
		do @(posedge clk); while (!text_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_text(string s, logic eot_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot_last && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (tokens_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic string random_word(int len, bit mixed);
		string s;
		s = "";
		for (int i = 0; i < len; i++)
			s = {s, string'(byte'((mixed && $urandom_range(0, 1) ? 65 : 97)
				+ $urandom_range(0, 25)))};
		return s;
	endfunction

	function automatic string random_digits(int len);
		string s;
		s = "";
		for (int i = 0; i < len; i++)
			s = {s, string'(byte'(48 + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string random_token();
		string s;
		byte   b;
		case ($urandom_range(0, 11))
			0, 1: s = random_word($urandom_range(1, 8), 1);
			2: s = $urandom_range(0, 1) ? random_word(3, 1) : random_word(2, 1);
			3: begin
				s = $urandom_range(0, 1) ? "yes" : "no";
				s = $urandom_range(0, 1) ? s.toupper() : s;
				if ($urandom_range(0, 1))
					s = {"\"", s, "\""};
			end
			4: begin
				s = random_digits($urandom_range(1, 12));
				if ($urandom_range(0, 1))
					s = {"-", s};
			end
			5: case ($urandom_range(0, 5))
				0: s = "-9223372036854775808";
				1: s = "9223372036854775807";
				2: s = "9223372036854775808";
				3: s = "-9223372036854775809";
				4: s = "-";
				default: s = random_digits(25);
			endcase
			6: begin
				s = "\"";
				for (int i = $urandom_range(0, 1) == 0 && $urandom_range(0, 9) == 0
						? 70 : $urandom_range(0, 10); i > 0; i--) begin
					b = byte'($urandom_range(0, 255));
					if (b == "\"")
						b = " ";
					s = {s, string'(b)};
				end
				s = {s, "\""};
			end
			7: s = {random_digits($urandom_range(1, 4)), ".", random_digits($urandom_range(0, 4))};
			8: s = {random_digits(2), random_word(1, 0)};
			9: case ($urandom_range(0, 4))
				0: s = "=";
				1: s = "{";
				2: s = "}";
				3: s = "<";
				default: s = ">";
			endcase
			10: s = string'(byte'($urandom_range(128, 255)));
			default: s = string'(byte'($urandom_range(0, 255)));
		endcase
		return s;
	endfunction

	task automatic send_script();
		string s;
		int    n;
		s = "";
		n = $urandom_range(4, 14);
		for (int i = 0; i < n; i++) begin
			s = {s, random_token()};
			case ($urandom_range(0, 5))
				0: s = {s, "\n"};
				1: s = {s, "\t"};
				2: ;
				default: s = {s, " "};
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			s = {s, random_token()};
		send_text(s, 1'b1);
	endtask

	task automatic run_phase(int idle, int stall, int count);
		int target;
		send_idle_pct = idle;
		stall_pct = stall;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_script();
	endtask

	initial begin
		bytes_sent = 0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty quote, specials, capitalized bool, decimal, quoted newline, pending token at end
		send_text("\"\"{-}<Yes>1.5=\"a\n\"", 1'b0);
		send_byte("x", 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);

		// hold off until every token has come out
		wait_drained();

		run_phase(0, 0, 75);
		run_phase(70, 0, 75);
		wait_drained();
		run_phase(0, 70, 75);
		run_phase(37, 37, 75);
		send_text("z", 1'b1);

		wait_drained();
		if (mismatch_count == 0 && tokens_pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
